// ----- hdl/rgb_channel_histogram_core_defines.svh -----
// ----------------------------------------------------------------------------
// RGB channel histogram assertion macros
// Shared property forms for the checker of the histogram core. Each macro
// expects signals named clock and reset in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef RGB_CHANNEL_HISTOGRAM_CORE_DEFINES_SVH
`define RGB_CHANNEL_HISTOGRAM_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RGBH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RGBH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/rgbh_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB channel histogram package
// Constants, command codes and the result type shared by the histogram core,
// its bin store and its checker.
// ----------------------------------------------------------------------------
package rgbh_pkg;

   // Bins per histogram and the index width that addresses them.
   localparam int BIN_COUNT      = 256;
   localparam int BIN_BITS       = $clog2(BIN_COUNT);

   // Default counter width and the fixed width of a reported total.
   localparam int COUNT_BITS_DEF = 32;
   localparam int TOTAL_BITS     = 32;

   // Number of color channels that are counted.
   localparam int CHAN_COUNT     = 3;

   // Request command codes.
   typedef enum logic {
      CMD_COUNT = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   // One response: the three totals of a bin.
   typedef struct packed {
      logic [TOTAL_BITS-1:0] red_total;
      logic [TOTAL_BITS-1:0] green_total;
      logic [TOTAL_BITS-1:0] blue_total;
   } result_type;

endpackage

// ----- hdl/rgbh_bin_store.sv -----
// ----------------------------------------------------------------------------
// RGB channel histogram bin store
// One histogram: a 256-entry counter memory with per-entry valid bits, a
// registered read, a saturating increment and write-back, and a bypass of
// the previous write so back-to-back hits on one bin see the newest count.
// ----------------------------------------------------------------------------
module rgbh_bin_store #(
   parameter int COUNT_BITS = rgbh_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rgbh_pkg::BIN_BITS-1:0] addr_in,
   input  logic                          bump,
   output logic [COUNT_BITS-1:0]         bin_value
);
   import rgbh_pkg::*;

   logic [COUNT_BITS-1:0] mem_ff [BIN_COUNT];
   logic [BIN_COUNT-1:0]  valid_ff;

   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  rd_valid_ff;
   logic [BIN_BITS-1:0]   addr_ff;

   logic                  fw_en_ff;
   logic [BIN_BITS-1:0]   fw_addr_ff;
   logic [COUNT_BITS-1:0] fw_data_ff;

   logic [COUNT_BITS-1:0] bin_in;

   // Registered read of the bin named by the incoming request.
   always_ff @(posedge clock) begin
      rd_data_ff  <= mem_ff[addr_in];
      rd_valid_ff <= valid_ff[addr_in];
      addr_ff     <= addr_in;
   end

   // The current count: the write of the previous cycle wins over the
   // memory, and a bin that was never written reads as zero.
   always_comb begin
      if (fw_en_ff && (fw_addr_ff == addr_ff)) begin
         bin_value = fw_data_ff;
      end else if (rd_valid_ff) begin
         bin_value = rd_data_ff;
      end else begin
         bin_value = '0;
      end
   end

   // Saturating increment.
   assign bin_in = (&bin_value) ? bin_value : bin_value + COUNT_BITS'(1);

   // Write-back of the incremented count.
   always_ff @(posedge clock) begin
      if (bump) begin
         mem_ff[addr_ff] <= bin_in;
      end
   end

   // Valid bits clear at reset and mark every bin written since.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (bump) begin
         valid_ff[addr_ff] <= 1'b1;
      end
   end

   // Bypass register for the write that the next read cannot yet see.
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_en_ff <= 1'b0;
      end else begin
         fw_en_ff <= bump;
      end
   end

   always_ff @(posedge clock) begin
      fw_addr_ff <= addr_ff;
      fw_data_ff <= bin_in;
   end

endmodule

// ----- hdl/rgb_channel_histogram_core.sv -----
// ----------------------------------------------------------------------------
// Path: a read request accepted at a clock edge is held in stage one, then
// written into the response buffer, whose head is offered on rsp_.
// Throughput: one request per cycle while req_stall is low, set by the single
// read-modify-write pass through each bin memory; req_stall rises when the
// two-entry response buffer will be full after the edge, which keeps room for
// a read still in stage one. Reset is synchronous and clears all bins at once.
// ----------------------------------------------------------------------------
// RGB channel histogram core
// Counts the red, green and blue bytes of each pixel into three 256-bin
// saturating histograms and answers read requests with the three counts of
// one bin.
// ----------------------------------------------------------------------------
module rgb_channel_histogram_core #(
   parameter int COUNT_BITS = rgbh_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [7:0]                      req_chan_red,
   input  logic [7:0]                      req_chan_green,
   input  logic [7:0]                      req_chan_blue,
   input  logic [rgbh_pkg::BIN_BITS-1:0]   req_bin_index,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rgbh_pkg::TOTAL_BITS-1:0] rsp_red_total,
   output logic [rgbh_pkg::TOTAL_BITS-1:0] rsp_green_total,
   output logic [rgbh_pkg::TOTAL_BITS-1:0] rsp_blue_total
);
   import rgbh_pkg::*;

   logic                  s1_valid_ff;
   cmd_type               s1_cmd_ff;

   logic [BIN_BITS-1:0]   chan_addr  [CHAN_COUNT];
   logic [COUNT_BITS-1:0] chan_value [CHAN_COUNT];
   logic [TOTAL_BITS-1:0] chan_total [CHAN_COUNT];

   logic                  bump;
   logic                  push;
   logic                  pop;
   result_type            result;

   logic [1:0]            level_ff;
   logic [1:0]            level_in;
   result_type            head_ff;
   result_type            spare_ff;

   // Each histogram reads the pixel byte on a count and the bin on a read.
   always_comb begin
      if (cmd_type'(req_cmd) == CMD_READ) begin
         chan_addr[0] = req_bin_index;
         chan_addr[1] = req_bin_index;
         chan_addr[2] = req_bin_index;
      end else begin
         chan_addr[0] = req_chan_red;
         chan_addr[1] = req_chan_green;
         chan_addr[2] = req_chan_blue;
      end
   end

   // Stage one holds the accepted request while its bins are read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_valid && !req_stall;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff <= cmd_type'(req_cmd);
   end

   assign bump = s1_valid_ff && (s1_cmd_ff == CMD_COUNT);
   assign push = s1_valid_ff && (s1_cmd_ff == CMD_READ);

   // One bin store per channel, and the clamp or extension of its count to 32 bits.
   for (genvar ch = 0; ch < CHAN_COUNT; ch++) begin : g_chan
      rgbh_bin_store #(
         .COUNT_BITS (COUNT_BITS)
      ) u_store (
         .clock     (clock),
         .reset     (reset),
         .addr_in   (chan_addr[ch]),
         .bump      (bump),
         .bin_value (chan_value[ch])
      );

      if (COUNT_BITS > TOTAL_BITS) begin : g_clamp
         assign chan_total[ch] = (|chan_value[ch][COUNT_BITS-1:TOTAL_BITS]) ?
                                 '1 : chan_value[ch][TOTAL_BITS-1:0];
      end else begin : g_extend
         assign chan_total[ch] = TOTAL_BITS'(chan_value[ch]);
      end
   end

   assign result.red_total   = chan_total[0];
   assign result.green_total = chan_total[1];
   assign result.blue_total  = chan_total[2];

   // Two-entry response buffer; the request side stalls only when it fills.
   assign rsp_valid = (level_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign level_in  = level_ff + {1'b0, push} - {1'b0, pop};
   assign req_stall = (level_in > 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 2'd0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      case (level_ff)
         2'd0: begin
            if (push) begin
               head_ff <= result;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_ff <= result;
            end else if (push) begin
               spare_ff <= result;
            end
         end
         default: begin
            if (pop) begin
               head_ff <= spare_ff;
            end
            if (push) begin
               spare_ff <= result;
            end
         end
      endcase
   end

   assign rsp_red_total   = head_ff.red_total;
   assign rsp_green_total = head_ff.green_total;
   assign rsp_blue_total  = head_ff.blue_total;

endmodule

// ----- hdl/rgbh_checker.sv -----
// ----------------------------------------------------------------------------
// RGB channel histogram checker
// Watches the ports of the histogram core and checks response ordering,
// buffering and flow control over time.
// ----------------------------------------------------------------------------
`include "rgb_channel_histogram_core_defines.svh"

module rgbh_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_cmd,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [rgbh_pkg::TOTAL_BITS-1:0] rsp_red_total,
   input logic [rgbh_pkg::TOTAL_BITS-1:0] rsp_green_total,
   input logic [rgbh_pkg::TOTAL_BITS-1:0] rsp_blue_total
);
   import rgbh_pkg::*;

   // A held response keeps its totals.
   `RGBH_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_red_total) && $stable(rsp_green_total) && $stable(rsp_blue_total), "stalled response changed")

   // A response appearing from an empty buffer comes from a read that went through stage one.
   `RGBH_ASSERT_NOW(a_rsp_from_read, $rose(rsp_valid), $past(req_valid && !req_stall && (req_cmd == CMD_READ), 2), "response without a read request")

   // With no response pending and no read in flight, none appears next cycle.
   `RGBH_ASSERT_NEXT(a_no_spurious_rsp, !rsp_valid && !$past(req_valid && !req_stall && (req_cmd == CMD_READ)), !rsp_valid, "response from a count request")

   // An empty response buffer never holds off requests.
   `RGBH_ASSERT_NOW(a_no_idle_stall, !rsp_valid, !req_stall, "request stalled while output is empty")

endmodule

bind rgb_channel_histogram_core rgbh_checker u_rgbh_checker (.*);
